// ===== hw/rtl/gcsl_pkg.sv =====
// shared types, constants and the sigmoid table of the gru step unit
`timescale 1ns / 1ps
package gcsl_pkg;

  localparam int HIDDEN_DEF      = 64;
  localparam int VOCAB_DEF       = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam logic [6:0] VOCAB_SIZE_RST = 7'd64;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // weight_sel codes
  localparam logic [2:0] SEL_UPD   = 3'd0;
  localparam logic [2:0] SEL_RST   = 3'd1;
  localparam logic [2:0] SEL_CAND  = 3'd2;
  localparam logic [2:0] SEL_OUT   = 3'd3;
  localparam logic [2:0] SEL_BUPD  = 3'd4;
  localparam logic [2:0] SEL_BRST  = 3'd5;
  localparam logic [2:0] SEL_BCAND = 3'd6;
  localparam logic [2:0] SEL_BOUT  = 3'd7;

  // which matrix a pass runs over
  typedef enum logic [1:0] {
    P_Z = 2'd0,
    P_R = 2'd1,
    P_C = 2'd2,
    P_O = 2'd3
  } pass_t;

  // kind of term in the accumulate pipeline
  typedef enum logic [1:0] {
    K_BIAS = 2'd0,
    K_TOK  = 2'd1,
    K_PROD = 2'd2,
    K_NONE = 2'd3
  } term_t;

  localparam logic [12:0] Q12_ONE = 13'd4096;
  localparam logic [12:0] SIG_MAX = 13'd4095;

  // sigmoid at steps of 0.5 from 0 to 8, q.12
  function automatic logic [12:0] sig_tab(input logic [4:0] idx);
    logic [12:0] r;
    case (idx)
      5'd0:    r = 13'd2048;
      5'd1:    r = 13'd2550;
      5'd2:    r = 13'd2994;
      5'd3:    r = 13'd3349;
      5'd4:    r = 13'd3608;
      5'd5:    r = 13'd3785;
      5'd6:    r = 13'd3902;
      5'd7:    r = 13'd3976;
      5'd8:    r = 13'd4022;
      5'd9:    r = 13'd4051;
      5'd10:   r = 13'd4069;
      5'd11:   r = 13'd4079;
      5'd12:   r = 13'd4086;
      5'd13:   r = 13'd4090;
      5'd14:   r = 13'd4092;
      5'd15:   r = 13'd4094;
      default: r = 13'd4095;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/gru_cell_step_logits_unit.sv =====
// gru cell step unit: weight stores, hidden vector and one shared mac sequencer
`timescale 1ns / 1ps
// One GRU step per cmd=1 beat: the block runs the update, reset and
// candidate gate rows, then one output row per active vocabulary entry,
// all on a single multiply-accumulate unit that also serves the sigmoid
// interpolation and the gate mixing. A gate row issues HIDDEN+2 terms
// (bias, token column, then the products), drains the three stage
// accumulate pipeline, then runs the activation; an output row drains
// the same way and then holds its logit beat for as long as it is stalled.
// in_stall stays high for the whole step. Weight write and clear beats
// return nothing. Weight and bias stores power up undefined and must be
// written before a step reads them; the hidden vector starts at zero
// after reset and after a clear beat.
module gru_cell_step_logits_unit
  import gcsl_pkg::*;
#(
  parameter int HIDDEN      = HIDDEN_DEF,
  parameter int VOCAB       = VOCAB_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [6:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic [2:0]          weight_sel,
  input  logic [5:0]          weight_row,
  input  logic [6:0]          weight_col,
  input  logic signed [15:0]  weight_value,
  input  logic [5:0]          token_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [5:0]          logit_index,
  output logic signed [31:0]  logit_value,
  output logic                last_logit
);

  // widths
  localparam int GCOLS = HIDDEN + VOCAB;
  localparam int HAW   = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
  localparam int VAW   = (VOCAB > 1) ? $clog2(VOCAB) : 1;
  localparam int CW    = $clog2(GCOLS);
  localparam int MX    = (HIDDEN > VOCAB) ? HIDDEN : VOCAB;
  localparam int RW    = (MX > 1) ? $clog2(MX) : 1;
  localparam int KW    = $clog2(HIDDEN + 3);
  localparam int AW    = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;
  localparam int PW    = AW + 16;
  localparam int SW    = PW + 2;

  localparam logic signed [33:0] WMAX = (34'sd1 <<< (WEIGHT_BITS - 1)) - 34'sd1;
  localparam logic signed [33:0] WMIN = -(34'sd1 <<< (WEIGHT_BITS - 1));
  localparam logic signed [SW-1:0] S32MAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] S32MIN = SW'(-64'sd2147483648);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MAC  = 10'b0000000010,
    S_ACT0 = 10'b0000000100,
    S_ACT1 = 10'b0000001000,
    S_RH   = 10'b0000010000,
    S_RH2  = 10'b0000100000,
    S_MIX1 = 10'b0001000000,
    S_MIX2 = 10'b0010000000,
    S_MIX3 = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  // stores
  logic signed [WEIGHT_BITS-1:0] ugm [HIDDEN][GCOLS];
  logic signed [WEIGHT_BITS-1:0] rgm [HIDDEN][GCOLS];
  logic signed [WEIGHT_BITS-1:0] cgm [HIDDEN][GCOLS];
  logic signed [WEIGHT_BITS-1:0] owm [VOCAB][HIDDEN];
  logic signed [WEIGHT_BITS-1:0] gbm [3][HIDDEN];
  logic signed [WEIGHT_BITS-1:0] obm [VOCAB];
  logic signed [15:0]            hm  [2][HIDDEN];
  logic signed [15:0]            rhm [HIDDEN];
  logic [12:0]                   zm  [HIDDEN];

  // control
  state_t         state;
  pass_t          pass;
  logic [RW-1:0]  i;
  logic [KW-1:0]  k;
  logic [5:0]     tok;
  logic [RW-1:0]  last_row_o;
  logic [6:0]     vocab_size;
  logic           hz;
  logic           cur;
  logic           s1_v, s2_v;
  term_t          s1_kind, s2_kind;

  // datapath
  logic signed [WEIGHT_BITS-1:0] ug_q, rg_q, cg_q, ow_q, gb_q, ob_q;
  logic signed [15:0]            h_q, rh_q, hx;
  logic [12:0]                   z_q;
  logic signed [PW-1:0]          p, mixa;
  logic signed [31:0]            acc, s2_raw;
  logic [12:0]                   base, sg;
  logic                          neg, asat;

  logic                 acc_in, adv;
  logic [RW-1:0]        last_row;
  logic [6:0]           nv_c;
  logic [CW-1:0]        mac_col, tok_col, gcol;
  logic [HAW-1:0]       hcol;
  logic [1:0]           gsel;
  logic                 g_ok, o_ok;
  logic signed [33:0]   vext, vcl;
  logic signed [WEIGHT_BITS-1:0] wv, w_sel;
  logic signed [15:0]   x_sel, mb;
  logic signed [AW-1:0] ma;
  logic signed [31:0]   bias32;
  logic signed [SW-1:0] term, sum;
  logic signed [33:0]   xs, xa;
  logic [3:0]           sidx;
  logic [10:0]          frac;
  logic [12:0]          diff, y, sg_next;
  logic signed [14:0]   ht;
  logic [13:0]          omz;
  logic signed [PW:0]   msum;
  logic signed [PW-1:0] q12p;
  logic signed [PW:0]   q12m;
  logic signed [15:0]   rh_new, hn_new;

  assign acc_in   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // result beat straight from the accumulator, held while stalled
  assign logit_index = 6'(i);
  assign logit_value = acc;
  assign last_logit  = (i == last_row_o);

  // write decode with saturation of the value to the stored width
  always_comb begin
    vext = 34'(weight_value);
    if (vext > WMAX) begin
      vcl = WMAX;
    end else if (vext < WMIN) begin
      vcl = WMIN;
    end else begin
      vcl = vext;
    end
    wv   = WEIGHT_BITS'(vcl);
    g_ok = (32'(weight_row) < HIDDEN) &&
           (weight_col[6] ? (32'(weight_col[5:0]) < VOCAB)
                          : (32'(weight_col[5:0]) < HIDDEN));
    gcol = weight_col[6] ? (CW'(HIDDEN) + CW'(weight_col[5:0])) : CW'(weight_col[5:0]);
    o_ok = (32'(weight_row) < VOCAB) && !weight_col[6] && (32'(weight_col[5:0]) < HIDDEN);
  end

  always_comb begin
    if (vocab_size < 7'd2) begin
      nv_c = 7'd2;
    end else if (32'(vocab_size) > VOCAB) begin
      nv_c = 7'(VOCAB);
    end else begin
      nv_c = vocab_size;
    end
  end

  assign last_row = (pass == P_O) ? last_row_o : RW'(HIDDEN - 1);

  // read addresses: term k of the row while accumulating, row i afterwards
  assign tok_col = CW'(HIDDEN) + CW'(tok);
  assign mac_col = (k == KW'(1)) ? tok_col : CW'(k - KW'(2));
  assign hcol    = (state == S_MAC) ? HAW'(k - KW'(2)) : HAW'(i);
  assign gsel    = (pass == P_O) ? 2'd0 : pass;

  always_ff @(posedge clk) begin
    if (acc_in && cmd == CMD_WRITE) begin
      if (weight_sel == SEL_UPD && g_ok) ugm[HAW'(weight_row)][gcol] <= wv;
      if (weight_sel == SEL_RST && g_ok) rgm[HAW'(weight_row)][gcol] <= wv;
      if (weight_sel == SEL_CAND && g_ok) cgm[HAW'(weight_row)][gcol] <= wv;
      if (weight_sel == SEL_OUT && o_ok) owm[VAW'(weight_row)][HAW'(weight_col[5:0])] <= wv;
      if ((weight_sel == SEL_BUPD || weight_sel == SEL_BRST || weight_sel == SEL_BCAND) &&
          32'(weight_row) < HIDDEN) begin
        gbm[2'(weight_sel - SEL_BUPD)][HAW'(weight_row)] <= wv;
      end
      if (weight_sel == SEL_BOUT && 32'(weight_row) < VOCAB) obm[VAW'(weight_row)] <= wv;
    end
    if (state == S_ACT1 && pass == P_Z) zm[HAW'(i)] <= sg_next;
    if (state == S_RH2) rhm[HAW'(i)] <= rh_new;
    if (state == S_MIX3) hm[~cur][HAW'(i)] <= hn_new;

    ug_q <= ugm[HAW'(i)][mac_col];
    rg_q <= rgm[HAW'(i)][mac_col];
    cg_q <= cgm[HAW'(i)][mac_col];
    ow_q <= owm[VAW'(i)][HAW'(k - KW'(2))];
    gb_q <= gbm[gsel][HAW'(i)];
    ob_q <= obm[VAW'(i)];
    h_q  <= hm[cur][hcol];
    rh_q <= rhm[hcol];
    z_q  <= zm[HAW'(i)];
  end

  // hidden vector reads as zero after a clear
  assign hx = hz ? 16'sd0 : h_q;

  always_comb begin
    case (pass)
      P_Z:     w_sel = ug_q;
      P_R:     w_sel = rg_q;
      P_C:     w_sel = cg_q;
      default: w_sel = ow_q;
    endcase
    x_sel  = (pass == P_C) ? rh_q : hx;
    bias32 = (pass == P_O) ? 32'(ob_q) : 32'(gb_q);
  end

  // sigmoid front end, doubled input for tanh
  always_comb begin
    xs   = (pass == P_C) ? (34'(acc) <<< 1) : 34'(acc);
    xa   = xs[33] ? -xs : xs;
    sidx = xa[14:11];
    frac = xa[10:0];
    diff = sig_tab({1'b0, sidx} + 5'd1) - sig_tab({1'b0, sidx});
    y    = asat ? SIG_MAX : (base + 13'(p >>> 11));
    sg_next = neg ? (Q12_ONE - y) : y;
    ht   = $signed({1'b0, sg, 1'b0}) - 15'sd4096;
    omz  = {1'b0, Q12_ONE} - {1'b0, z_q};
  end

  // operand select of the one shared multiplier
  always_comb begin
    case (state)
      S_MAC: begin
        ma = AW'(w_sel);
        mb = x_sel;
      end
      S_ACT0: begin
        ma = AW'($signed({1'b0, diff}));
        mb = $signed({5'b0, frac});
      end
      S_RH: begin
        ma = AW'($signed({1'b0, sg}));
        mb = hx;
      end
      S_MIX1: begin
        ma = AW'($signed({1'b0, omz}));
        mb = hx;
      end
      S_MIX2: begin
        ma = AW'($signed({1'b0, z_q}));
        mb = 16'(ht);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // saturating accumulate and q.12 rounding toward minus infinity
  always_comb begin
    term = (s2_kind == K_TOK) ? SW'(s2_raw) : SW'(p >>> 12);
    sum  = SW'(acc) + term;
    q12p = p >>> 12;
    msum = (PW + 1)'(mixa) + (PW + 1)'(p);
    q12m = msum >>> 12;
    if (q12p > PW'(32767)) begin
      rh_new = 16'sd32767;
    end else if (q12p < -PW'(32768)) begin
      rh_new = -16'sd32768;
    end else begin
      rh_new = 16'(q12p);
    end
    if (q12m > (PW + 1)'(32767)) begin
      hn_new = 16'sd32767;
    end else if (q12m < -(PW + 1)'(32768)) begin
      hn_new = -16'sd32768;
    end else begin
      hn_new = 16'(q12m);
    end
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
    if (state == S_MIX2) mixa <= p;
    s2_raw <= (s1_kind == K_BIAS) ? bias32 : 32'(w_sel);
    if (s2_v) begin
      if (s2_kind == K_BIAS) begin
        acc <= s2_raw;
      end else if (sum > S32MAX) begin
        acc <= 32'(S32MAX);
      end else if (sum < S32MIN) begin
        acc <= 32'(S32MIN);
      end else begin
        acc <= 32'(sum);
      end
    end
    if (state == S_ACT0) begin
      base <= sig_tab({1'b0, sidx});
      neg  <= xs[33];
      asat <= (xa[33:15] != '0);
    end
    if (state == S_ACT1) sg <= sg_next;
  end

  // row finished, move on
  assign adv = (state == S_ACT1 && pass == P_Z) || state == S_RH2 || state == S_MIX3 ||
               (state == S_OUT && !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pass       <= P_Z;
      i          <= '0;
      k          <= '0;
      out_valid  <= 1'b0;
      hz         <= 1'b1;
      cur        <= 1'b0;
      vocab_size <= VOCAB_SIZE_RST;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      s1_kind    <= K_NONE;
      s2_kind    <= K_NONE;
    end else begin
      if (cfg_wr_en) vocab_size <= cfg_wr_data;
      s1_v    <= 1'b0;
      s2_v    <= s1_v;
      s2_kind <= s1_kind;
      case (state)
        S_IDLE: begin
          if (acc_in && cmd == CMD_STEP) begin
            pass       <= P_Z;
            i          <= '0;
            k          <= '0;
            tok        <= token_index;
            last_row_o <= RW'(nv_c - 7'd1);
            state      <= S_MAC;
          end else if (acc_in && cmd == CMD_CLEAR) begin
            hz <= 1'b1;
          end
        end
        S_MAC: begin
          if (32'(k) <= HIDDEN + 1) begin
            k <= k + KW'(1);
            if (k == '0) begin
              s1_v    <= 1'b1;
              s1_kind <= K_BIAS;
            end else if (k == KW'(1)) begin
              // output rows have no token column; a token past the stored
              // columns adds nothing
              s1_v    <= (pass != P_O) && (32'(tok) < VOCAB);
              s1_kind <= K_TOK;
            end else begin
              s1_v    <= 1'b1;
              s1_kind <= K_PROD;
            end
          end else if (!s1_v && !s2_v) begin
            if (pass == P_O) begin
              out_valid <= 1'b1;
              state     <= S_OUT;
            end else begin
              state <= S_ACT0;
            end
          end
        end
        S_ACT0: state <= S_ACT1;
        S_ACT1: begin
          case (pass)
            P_R:     state <= S_RH;
            P_C:     state <= S_MIX1;
            default: state <= S_ACT1;
          endcase
        end
        S_RH:   state <= S_RH2;
        S_MIX1: state <= S_MIX2;
        S_MIX2: state <= S_MIX3;
        S_OUT: begin
          if (!out_stall) out_valid <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
      if (adv) begin
        k     <= '0;
        state <= S_MAC;
        if (i == last_row) begin
          i <= '0;
          case (pass)
            P_Z: pass <= P_R;
            P_R: pass <= P_C;
            P_C: begin
              // new hidden vector now live in the other bank
              pass <= P_O;
              cur  <= ~cur;
              hz   <= 1'b0;
            end
            default: state <= S_IDLE;
          endcase
        end else begin
          i <= i + RW'(1);
        end
      end
    end
  end

  // checks
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT)
    else $error("logit beat outside output state");

  a_step_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd == CMD_STEP) |=> state == S_MAC && pass == P_Z)
    else $error("step beat did not start the update pass");

  a_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state != S_MAC) |-> (!s1_v && !s2_v))
    else $error("accumulate pipeline busy outside a row");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (pass == P_O && i <= last_row_o))
    else $error("logit row past active vocabulary");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the gru step unit with a bit-accurate predictor
`timescale 1ns / 1ps
module testbench;
  import gcsl_pkg::*;

  localparam int NH = 64;
  localparam int NV = 64;
  localparam int IDLE_LIMIT = 200000;  // a step stays quiet until its first logit
  localparam int SETTLE = 40;          // tail after the last logit of a step

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = CMD_WRITE;
  logic [2:0] weight_sel = '0;
  logic [5:0] weight_row = '0;
  logic [6:0] weight_col = '0;
  logic signed [15:0] weight_value = '0;
  logic [5:0] token_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] logit_index;
  logic signed [31:0] logit_value;
  logic last_logit;

  always #1 clk = ~clk;

  gru_cell_step_logits_unit dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .weight_sel(weight_sel), .weight_row(weight_row),
    .weight_col(weight_col), .weight_value(weight_value), .token_index(token_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .logit_index(logit_index), .logit_value(logit_value), .last_logit(last_logit)
  );

  // one input beat, or a register write when is_cfg is set
  typedef struct {
    bit is_cfg;
    cmd_t op;
    logic [2:0] sel;
    logic [5:0] row;
    logic [6:0] col;
    logic signed [15:0] val;
    logic [5:0] tok;
    int nres;  // logits typed in, -1 where only the predictor knows
  } beat_t;

  typedef struct {
    logic [5:0] idx;
    logic signed [31:0] val;
    logic last;
  } logit_t;

  // predictor copy of the block state
  int gate_w[3][NH][NH + NV];
  int out_w[NV][NH];
  int gate_b[3][NH];
  int out_b[NV];
  int hid[NH];
  int vocab_reg;
  logit_t pending_logits[$];

  int fail_count = 0;
  int quiet_cycles = 0;
  bit running = 1'b1;
  bit bursty = 1'b0;
  int burst_left = 0;

  // sigmoid knots, q.12, 0 to 8 in steps of 0.5
  const int knots[17] = '{2048, 2550, 2994, 3349, 3608, 3785, 3902, 3976, 4022,
                          4051, 4069, 4079, 4086, 4090, 4092, 4094, 4095};

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint sigmoid_q12(longint x);
    longint a, y, fr;
    int k;
    a = (x < 0) ? -x : x;
    if (a >= 32768) y = knots[16];
    else begin
      k = int'(a >>> 11);
      fr = a & 2047;
      y = knots[k] + ((longint'(knots[k + 1] - knots[k]) * fr) >>> 11);
    end
    return (x < 0) ? 4096 - y : y;
  endfunction

  function automatic longint tanh_q12(longint x);
    return 2 * sigmoid_q12(2 * x) - 4096;
  endfunction

  // pre-activation of one gate row over a given input vector
  function automatic longint gate_sum(int g, int r, int tok, const ref int vin[NH]);
    longint acc;
    acc = gate_b[g][r];
    acc = clip32(acc + gate_w[g][r][NH + tok]);
    for (int j = 0; j < NH; j++)
      acc = clip32(acc + ((longint'(gate_w[g][r][j]) * vin[j]) >>> 12));
    return acc;
  endfunction

  // one gru step: new hidden vector, then one logit per active entry
  task automatic predict_logits(int tok);
    longint z[NH], hc, ht, acc;
    int rh[NH], hn[NH], nv;
    logit_t e;
    nv = vocab_reg < 2 ? 2 : (vocab_reg > NV ? NV : vocab_reg);
    for (int i = 0; i < NH; i++) begin
      z[i] = sigmoid_q12(gate_sum(0, i, tok, hid));
      rh[i] = int'(clip16((sigmoid_q12(gate_sum(1, i, tok, hid)) * hid[i]) >>> 12));
    end
    for (int i = 0; i < NH; i++) begin
      hc = gate_sum(2, i, tok, rh);
      ht = tanh_q12(hc);
      hn[i] = int'(clip16(((4096 - z[i]) * hid[i] + z[i] * ht) >>> 12));
    end
    hid = hn;
    for (int i = 0; i < nv; i++) begin
      acc = out_b[i];
      for (int j = 0; j < NH; j++)
        acc = clip32(acc + ((longint'(out_w[i][j]) * hn[j]) >>> 12));
      e.idx = i[5:0];
      e.val = acc[31:0];
      e.last = (i == nv - 1);
      pending_logits = {pending_logits, e};
    end
  endtask

  // apply an accepted beat to the predictor state
  task automatic apply_beat(beat_t b);
    int before_n;
    before_n = pending_logits.size();
    case (b.op)
      CMD_WRITE: begin
        if (b.sel <= SEL_CAND) gate_w[b.sel][b.row][b.col] = b.val;
        else if (b.sel == SEL_OUT) begin
          if (b.col < NH) out_w[b.row][b.col] = b.val;  // output columns stop at 63
        end else if (b.sel == SEL_BOUT) out_b[b.row] = b.val;
        else gate_b[b.sel - SEL_BUPD][b.row] = b.val;
      end
      CMD_STEP: predict_logits(b.tok);
      CMD_CLEAR: foreach (hid[i]) hid[i] = 0;
      default: ;  // unused code, nothing happens
    endcase
    if (b.nres >= 0 && pending_logits.size() - before_n != b.nres) begin
      $error("nres: expected %0d actual %0d", b.nres, pending_logits.size() - before_n);
      fail_count++;
    end
  endtask

  // register write, only with the block idle and no beat offered
  task automatic write_vocab(logic [6:0] v);
    in_valid <= 1'b0;
    wait (pending_logits.size() == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    vocab_reg = v;
    cfg_wr_en <= 1'b0;
  endtask

  // hand one beat to the block and wait for it to be taken
  task automatic send_beat(beat_t b);
    int gap;
    if (b.is_cfg) begin
      write_vocab(b.col);
      return;
    end
    in_valid <= 1'b1;
    cmd <= b.op;
    weight_sel <= b.sel;
    weight_row <= b.row;
    weight_col <= b.col;
    weight_value <= b.val;
    token_index <= b.tok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_beat(b);
    if (bursty) begin
      if (burst_left > 0) burst_left--;
      else begin
        burst_left = $urandom_range(0, 6);
        gap = $urandom_range(1, 5);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic beat_t mk(cmd_t op, logic [2:0] sel, logic [5:0] row, logic [6:0] col,
                               logic signed [15:0] val, logic [5:0] tok, int nres);
    beat_t b;
    b.is_cfg = 1'b0; b.op = op; b.sel = sel; b.row = row; b.col = col;
    b.val = val; b.tok = tok; b.nres = nres;
    return b;
  endfunction

  function automatic beat_t mk_cfg(logic [6:0] v);
    beat_t b;
    b = mk(CMD_NONE, '0, '0, v, '0, '0, 0);
    b.is_cfg = 1'b1;
    return b;
  endfunction

  function automatic logic signed [15:0] soft_weight();
    return 16'($signed($urandom_range(0, 3072)) - 1536);
  endfunction

  // logit sink: checks each accepted beat, stall pattern changes by phase
  int stall_mode = 0;
  int stall_phase = 0;
  always @(posedge clk) begin
    logit_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_logits.size() == 0) begin
          $error("logit with nothing expected: index %0d value %0d", logit_index,
                 logit_value);
          fail_count++;
        end else begin
          e = pending_logits.pop_front();
          if (logit_index !== e.idx) begin
            $error("logit_index: expected %0d actual %0d", e.idx, logit_index);
            fail_count++;
          end
          if (logit_value !== e.val) begin
            $error("logit_value: expected %0d actual %0d", e.val, logit_value);
            fail_count++;
          end
          if (last_logit !== e.last) begin
            $error("last_logit: expected %0d actual %0d", e.last, last_logit);
            fail_count++;
          end
        end
      end
      // stretches of no stall, light stall and heavy stall
      if (stall_phase == 0) begin
        stall_phase = $urandom_range(20, 400);
        stall_mode = $urandom_range(0, 2);
      end else stall_phase--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // watchdog on cycles where neither side moves a beat
  always @(posedge clk) begin
    if (running) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  beat_t directed[$];
  beat_t rb;
  int pick;

  initial begin
    vocab_reg = VOCAB_SIZE_RST;
    foreach (hid[i]) hid[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every store a step can read, no gaps
    for (int g = 0; g < 3; g++)
      for (int r = 0; r < NH; r++) begin
        for (int c = 0; c < NH + NV; c++)
          send_beat(mk(CMD_WRITE, 3'(g), 6'(r), 7'(c), soft_weight(), '0, 0));
        send_beat(mk(CMD_WRITE, 3'(SEL_BUPD + g), 6'(r), '0, soft_weight(), '0, 0));
      end
    for (int r = 0; r < NV; r++) begin
      for (int c = 0; c < NH; c++)
        send_beat(mk(CMD_WRITE, SEL_OUT, 6'(r), 7'(c), soft_weight(), '0, 0));
      send_beat(mk(CMD_WRITE, SEL_BOUT, 6'(r), '0, soft_weight(), '0, 0));
    end

    // directed table: value extremes, ignored output column, every command,
    // token extremes and the vocab_size clamps
    directed = '{
      mk(CMD_WRITE, SEL_UPD, 6'd0, 7'd0, 16'sh7fff, 6'd0, 0),
      mk(CMD_WRITE, SEL_RST, 6'd63, 7'd127, -16'sh8000, 6'd0, 0),
      mk(CMD_WRITE, SEL_CAND, 6'd5, 7'd64, 16'sh7fff, 6'd0, 0),
      mk(CMD_WRITE, SEL_OUT, 6'd63, 7'd63, 16'sh7fff, 6'd0, 0),
      mk(CMD_WRITE, SEL_OUT, 6'd1, 7'd64, -16'sd1, 6'd0, 0),
      mk(CMD_WRITE, SEL_OUT, 6'd2, 7'd127, -16'sh8000, 6'd63, 0),
      mk(CMD_WRITE, SEL_BUPD, 6'd63, 7'd0, -16'sh8000, 6'd0, 0),
      mk(CMD_WRITE, SEL_BRST, 6'd0, 7'd0, 16'sh7fff, 6'd0, 0),
      mk(CMD_WRITE, SEL_BCAND, 6'd10, 7'd0, -16'sh8000, 6'd0, 0),
      mk(CMD_WRITE, SEL_BOUT, 6'd0, 7'd0, 16'sh7fff, 6'd0, 0),
      mk(CMD_NONE, 3'd7, 6'd63, 7'd127, -16'sd1, 6'd63, 0),
      mk(CMD_STEP, '0, '0, '0, '0, 6'd0, 64),
      mk(CMD_STEP, 3'd7, 6'd63, 7'd127, -16'sd1, 6'd63, 64),
      mk(CMD_CLEAR, '0, '0, '0, '0, '0, 0),
      mk(CMD_STEP, '0, '0, '0, '0, 6'd17, 64),
      mk_cfg(7'd2),
      mk(CMD_STEP, '0, '0, '0, '0, 6'd40, 2),
      mk_cfg(7'd0),
      mk(CMD_STEP, '0, '0, '0, '0, 6'd1, 2),
      mk_cfg(7'd1),
      mk(CMD_STEP, '0, '0, '0, '0, 6'd63, 2),
      mk_cfg(7'd127),
      mk(CMD_STEP, '0, '0, '0, '0, 6'd3, 64),
      mk_cfg(7'd64)
    };
    bursty = 1'b1;
    foreach (directed[i]) send_beat(directed[i]);

    // random part: mostly steps and rewrites, some clears and unused codes
    for (int n = 0; n < 100; n++) begin
      if (n % 16 == 15) begin
        pick = $urandom_range(0, 3);
        write_vocab(pick == 0 ? 7'd2 : pick == 1 ? 7'd64 : 7'($urandom_range(0, 127)));
      end
      pick = $urandom_range(0, 99);
      rb = mk(CMD_WRITE, 3'($urandom), 6'($urandom), 7'($urandom), 16'($urandom),
              6'($urandom), -1);
      if (pick < 35) rb.op = CMD_STEP;
      else if (pick < 41) rb.op = CMD_CLEAR;
      else if (pick < 46) rb.op = CMD_NONE;
      else if (pick < 70) rb.val = soft_weight();
      send_beat(rb);
    end
    in_valid <= 1'b0;

    wait (pending_logits.size() == 0);
    repeat (SETTLE) @(posedge clk);
    running = 1'b0;
    if (fail_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
